### rtl/spa_pkg.sv
// shared types and constants of the sparse polynomial adder
package spa_pkg;

    localparam int unsigned COEFF_W     = 32;
    localparam int unsigned POWER_W     = 8;
    localparam int unsigned SUM_W       = 33;
    localparam int unsigned MODE_W      = 2;
    localparam int unsigned IN_DATA_W   = 40;
    localparam int unsigned OUT_DATA_W  = 48;
    localparam int unsigned TERM_W      = COEFF_W + POWER_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD_A = 2'd0,
        MODE_LOAD_B = 2'd1,
        MODE_MERGE  = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_MERGE = 2'b10
    } t_state;

endpackage

### rtl/spa_ram.sv
// generic single-port-write ram with registered read
module spa_ram #(
    parameter int unsigned WIDTH = 40,
    parameter int unsigned DEPTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sparse_polynomial_adder.sv
// top level of the sparse polynomial adder: term stores and merge walk
//
// Input channel s_axis: one beat per term or command. tuser selects the kind:
// load a term into the first store, load into the second store, or merge.
// tready is high whenever no merge is running. A merge beat starts a walk
// over both stores. The first result term shows on m_axis once the state
// register and then the output register are loaded, then one term per cycle
// while the receiver is ready, paced by the single read port of each store.
// tready stays low until the last term is loaded; that term carries tlast,
// and tuser flags that a load found its store full since the previous merge.
// If the receiver stalls, the walk holds in place until the output register
// drains; a waiting result never blocks the next load beat once the walk ends.
// A merge with both stores empty gives no beat and frees the block at once.
// Reset clears the term counts and the overflow flag; the stores need no clear.
module sparse_polynomial_adder #(
    parameter int unsigned TERM_DEPTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [spa_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // term_coeff, term_power
    input  logic [spa_pkg::MODE_W-1:0]     s_axis_tuser,   // mode
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [spa_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // sum_coeff, sum_power
    output logic                           m_axis_tlast,   // last_term
    output logic                           m_axis_tuser    // terms_dropped
);

    localparam int unsigned CW = $clog2(TERM_DEPTH + 1);
    localparam int unsigned AW = (TERM_DEPTH > 1) ? $clog2(TERM_DEPTH) : 1;
    localparam int unsigned CW_PAD = spa_pkg::OUT_DATA_W - spa_pkg::SUM_W - spa_pkg::POWER_W;

    spa_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [CW-1:0]   r_ptr_a, n_ptr_a, r_ptr_b, n_ptr_b;
    logic            r_ovf, n_ovf;
    logic            r_out_valid, n_out_valid;
    logic [spa_pkg::SUM_W-1:0]   r_out_coeff;
    logic [spa_pkg::POWER_W-1:0] r_out_power;
    logic            r_out_last, r_out_drop;

    logic                          in_beat, out_load, we_a, we_b;
    logic                          a_ok, b_ok, take_a, take_b, last;
    spa_pkg::t_mode                in_mode;
    logic [spa_pkg::TERM_W-1:0]    rd_a, rd_b;
    logic [spa_pkg::COEFF_W-1:0]   coeff_a, coeff_b;
    logic [spa_pkg::POWER_W-1:0]   power_a, power_b;
    logic [spa_pkg::SUM_W-1:0]     add_a, add_b, sum;

    assign in_mode  = spa_pkg::t_mode'(s_axis_tuser);
    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_load = (r_state == spa_pkg::ST_MERGE) && (!r_out_valid || m_axis_tready);

    assign we_a = in_beat && (in_mode == spa_pkg::MODE_LOAD_A)
                  && (r_cnt_a < CW'(TERM_DEPTH));
    assign we_b = in_beat && (in_mode == spa_pkg::MODE_LOAD_B)
                  && (r_cnt_b < CW'(TERM_DEPTH));

    spa_ram #(.WIDTH(spa_pkg::TERM_W), .DEPTH(TERM_DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (s_axis_tdata[spa_pkg::TERM_W-1:0]),
        .i_raddr (n_ptr_a[AW-1:0]),
        .o_rdata (rd_a)
    );

    spa_ram #(.WIDTH(spa_pkg::TERM_W), .DEPTH(TERM_DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (s_axis_tdata[spa_pkg::TERM_W-1:0]),
        .i_raddr (n_ptr_b[AW-1:0]),
        .o_rdata (rd_b)
    );

    assign coeff_a = rd_a[spa_pkg::COEFF_W-1:0];
    assign power_a = rd_a[spa_pkg::TERM_W-1:spa_pkg::COEFF_W];
    assign coeff_b = rd_b[spa_pkg::COEFF_W-1:0];
    assign power_b = rd_b[spa_pkg::TERM_W-1:spa_pkg::COEFF_W];

    assign a_ok   = r_ptr_a < r_cnt_a;
    assign b_ok   = r_ptr_b < r_cnt_b;
    assign take_a = a_ok && (!b_ok || (power_a >= power_b));
    assign take_b = b_ok && (!a_ok || (power_b >= power_a));

    assign add_a = take_a ? {coeff_a[spa_pkg::COEFF_W-1], coeff_a} : '0;
    assign add_b = take_b ? {coeff_b[spa_pkg::COEFF_W-1], coeff_b} : '0;
    assign sum   = add_a + add_b;

    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_ptr_a     = r_ptr_a;
        n_ptr_b     = r_ptr_b;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && !m_axis_tready;
        last        = 1'b0;
        unique case (r_state)
            spa_pkg::ST_IDLE: begin
                if (in_beat) begin
                    case (in_mode)
                        spa_pkg::MODE_LOAD_A: begin
                            if (we_a) n_cnt_a = r_cnt_a + CW'(1);
                            else      n_ovf   = 1'b1;
                        end
                        spa_pkg::MODE_LOAD_B: begin
                            if (we_b) n_cnt_b = r_cnt_b + CW'(1);
                            else      n_ovf   = 1'b1;
                        end
                        spa_pkg::MODE_MERGE: begin
                            if (r_cnt_a == '0 && r_cnt_b == '0) n_ovf = 1'b0;
                            else                                n_state = spa_pkg::ST_MERGE;
                        end
                        default: ;
                    endcase
                end
            end
            spa_pkg::ST_MERGE: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_ptr_a     = r_ptr_a + CW'(take_a);
                    n_ptr_b     = r_ptr_b + CW'(take_b);
                    last        = (n_ptr_a >= r_cnt_a) && (n_ptr_b >= r_cnt_b);
                    if (last) begin
                        n_state = spa_pkg::ST_IDLE;
                        n_cnt_a = '0;
                        n_cnt_b = '0;
                        n_ptr_a = '0;
                        n_ptr_b = '0;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: n_state = spa_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spa_pkg::ST_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_ptr_a     <= '0;
            r_ptr_b     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_ptr_a     <= n_ptr_a;
            r_ptr_b     <= n_ptr_b;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_coeff <= sum;
            r_out_power <= take_a ? power_a : power_b;
            r_out_last  <= last;
            r_out_drop  <= r_ovf;
        end
    end

    assign s_axis_tready = (r_state == spa_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{CW_PAD{1'b0}}, r_out_power, r_out_coeff};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_drop;

endmodule

### rtl/spa_checker.sv
// port-level checks of the sparse polynomial adder, bound to the top level
module spa_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [spa_pkg::MODE_W-1:0]     s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [spa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tlast
);

    // no result beat right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat after reset");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast))
        else $error("stalled result beat changed");

    // input side closes only after a merge beat
    a_close_on_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid)
        && ($past(s_axis_tuser) == spa_pkg::MODE_MERGE))
        else $error("input closed without a merge beat");

    // a fresh result beat comes from a running merge
    a_beat_from_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result beat outside a merge");

    // a term that is not the last one means the merge is still running
    a_busy_mid_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input open in the middle of a merge");

endmodule

bind sparse_polynomial_adder spa_checker u_spa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
